### rtl/blr_pkg.sv
package blr_pkg;

  localparam int COORD_W  = 9;
  localparam int ROW_W    = 8;
  localparam int COLOUR_W = 16;
  localparam int ADDR_W   = 32;
  localparam int ERR_W    = 11;

  localparam int ROW_SHIFT = 10;
  localparam int COL_SHIFT = 1;

  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 240;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic                    steep;
    logic [COORD_W-1:0]      major_pos;
    logic [COORD_W-1:0]      major_end;
    logic [COORD_W-1:0]      minor_pos;
    logic                    minor_step_down;
    logic [COORD_W-1:0]      major_delta;
    logic [COORD_W-1:0]      minor_delta;
    logic signed [ERR_W-1:0] err_init;
  } line_setup_t;

  typedef struct packed {
    logic [COORD_W-1:0]  px;
    logic [COORD_W-1:0]  py;
    logic [COLOUR_W-1:0] colour;
    logic                last;
  } pixel_t;

endpackage

### rtl/bresenham_line_raster.sv
// Bresenham line engine. A start transaction (cmd 0) clamps both endpoints
// to the screen and loads the line; it returns nothing and replaces any line
// in progress. Each tick transaction (cmd 1) returns one pixel with its byte
// address frame_base + y*1024 + x*2, walking from the lower end of the major
// axis, both endpoints included; the final pixel has last_pixel set and the
// engine goes idle, so ticks after that return nothing. One transaction is
// taken per cycle, start or tick, unless cmd_stall holds it while the output
// is stalled; a pixel passes the input register, then the result register,
// with setup and step logic between. The user must write frame_base (cfg_we,
// cfg_wdata) only while the engine is idle; the block does not enforce this.
module bresenham_line_raster
  import blr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [ADDR_W-1:0]   cfg_wdata,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  logic                cmd,
  input  logic [COORD_W-1:0]  start_x,
  input  logic [ROW_W-1:0]    start_y,
  input  logic [COORD_W-1:0]  end_x,
  input  logic [ROW_W-1:0]    end_y,
  input  logic [COLOUR_W-1:0] pen_colour,
  output logic                pixel_valid,
  input  logic                pixel_stall,
  output logic [COORD_W-1:0]  pixel_x,
  output logic [ROW_W-1:0]    pixel_y,
  output logic [ADDR_W-1:0]   pixel_addr,
  output logic [COLOUR_W-1:0] pixel_colour,
  output logic                last_pixel
);

  localparam logic [COORD_W-1:0] X_MAX = COORD_W'(SCREEN_WIDTH - 1);
  localparam logic [COORD_W-1:0] Y_MAX = COORD_W'(SCREEN_HEIGHT - 1);

  logic [ADDR_W-1:0]   frame_base;

  logic                s1_valid;
  logic                s1_cmd;
  logic [COORD_W-1:0]  s1_start_x;
  logic [ROW_W-1:0]    s1_start_y;
  logic [COORD_W-1:0]  s1_end_x;
  logic [ROW_W-1:0]    s1_end_y;
  logic [COLOUR_W-1:0] s1_colour;

  logic                out_free;
  logic                advance;
  logic                accept;
  logic                emit;
  line_setup_t         setup;
  pixel_t              pixel;
  logic [ADDR_W-1:0]   addr_next;

  assign out_free  = !pixel_valid || !pixel_stall;
  assign advance   = s1_valid && out_free;
  assign cmd_stall = s1_valid && !out_free;
  assign accept    = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base <= '0;
    end else if (cfg_we) begin
      frame_base <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd     <= cmd;
      s1_start_x <= start_x;
      s1_start_y <= start_y;
      s1_end_x   <= end_x;
      s1_end_y   <= end_y;
      s1_colour  <= pen_colour;
    end
  end

  blr_setup #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_setup (
    .start_x (s1_start_x),
    .start_y (s1_start_y),
    .end_x   (s1_end_x),
    .end_y   (s1_end_y),
    .setup   (setup)
  );

  blr_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .step_en    (advance),
    .cmd        (s1_cmd),
    .setup      (setup),
    .pen_colour (s1_colour),
    .emit       (emit),
    .pixel      (pixel)
  );

  assign addr_next = frame_base + (ADDR_W'(pixel.py) << ROW_SHIFT)
                     + (ADDR_W'(pixel.px) << COL_SHIFT);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (out_free) begin
      pixel_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      pixel_x      <= pixel.px;
      pixel_y      <= pixel.py[ROW_W-1:0];
      pixel_addr   <= addr_next;
      pixel_colour <= pixel.colour;
      last_pixel   <= pixel.last;
    end
  end

  a_pixel_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(pixel_valid) |-> $past(advance && (s1_cmd == CMD_TICK)))
    else $error("pixel transaction without a tick");

  a_pixel_on_screen: assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> (pixel_x <= X_MAX) && (COORD_W'(pixel_y) <= Y_MAX))
    else $error("pixel off screen");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> pixel_valid && s1_valid)
    else $error("input stalled with room downstream");

endmodule

### rtl/blr_setup.sv
module blr_setup
  import blr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic [COORD_W-1:0] start_x,
  input  logic [ROW_W-1:0]   start_y,
  input  logic [COORD_W-1:0] end_x,
  input  logic [ROW_W-1:0]   end_y,
  output line_setup_t        setup
);

  localparam logic [COORD_W-1:0] X_MAX = COORD_W'(SCREEN_WIDTH - 1);
  localparam logic [COORD_W-1:0] Y_MAX = COORD_W'(SCREEN_HEIGHT - 1);

  logic [COORD_W-1:0] x0, y0, x1, y1;
  logic [COORD_W-1:0] sy0, sy1;
  logic [COORD_W-1:0] dx, dy;
  logic               steep;
  logic [COORD_W-1:0] a0, b0, a1, b1;
  logic [COORD_W-1:0] ma0, mb0, ma1, mb1;
  logic [COORD_W-1:0] major_delta;

  // clamp endpoints to the screen
  always_comb begin
    sy0 = COORD_W'(start_y);
    sy1 = COORD_W'(end_y);
    x0 = (start_x > X_MAX) ? X_MAX : start_x;
    x1 = (end_x > X_MAX) ? X_MAX : end_x;
    y0 = (sy0 > Y_MAX) ? Y_MAX : sy0;
    y1 = (sy1 > Y_MAX) ? Y_MAX : sy1;
  end

  assign dx    = (x1 > x0) ? (x1 - x0) : (x0 - x1);
  assign dy    = (y1 > y0) ? (y1 - y0) : (y0 - y1);
  assign steep = dy > dx;

  always_comb begin
    if (steep) begin
      a0 = y0; b0 = x0; a1 = y1; b1 = x1;
    end else begin
      a0 = x0; b0 = y0; a1 = x1; b1 = y1;
    end
    if (a0 > a1) begin
      ma0 = a1; mb0 = b1; ma1 = a0; mb1 = b0;
    end else begin
      ma0 = a0; mb0 = b0; ma1 = a1; mb1 = b1;
    end
  end

  assign major_delta = ma1 - ma0;

  always_comb begin
    setup.steep           = steep;
    setup.major_pos       = ma0;
    setup.major_end       = ma1;
    setup.minor_pos       = mb0;
    setup.major_delta     = major_delta;
    setup.minor_delta     = (mb1 > mb0) ? (mb1 - mb0) : (mb0 - mb1);
    setup.minor_step_down = !(mb0 < mb1);
    setup.err_init        = $signed(ERR_W'(0) -
                            {{(ERR_W-COORD_W+1){1'b0}}, major_delta[COORD_W-1:1]});
  end

endmodule

### rtl/blr_walk.sv
module blr_walk
  import blr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                step_en,
  input  logic                cmd,
  input  line_setup_t         setup,
  input  logic [COLOUR_W-1:0] pen_colour,
  output logic                emit,
  output pixel_t              pixel
);

  logic                    active;
  logic                    steep;
  logic [COORD_W-1:0]      major_pos;
  logic [COORD_W-1:0]      major_end;
  logic [COORD_W-1:0]      minor_pos;
  logic                    minor_step_down;
  logic [COORD_W-1:0]      major_delta;
  logic [COORD_W-1:0]      minor_delta;
  logic signed [ERR_W-1:0] err_term;
  logic [COLOUR_W-1:0]     line_colour;

  logic                    last;
  logic signed [ERR_W-1:0] err_sum;
  logic signed [ERR_W-1:0] err_sub;
  logic                    minor_move;

  assign last       = major_pos == major_end;
  assign emit       = step_en && (cmd == CMD_TICK) && active;
  assign err_sum    = err_term + $signed({{(ERR_W-COORD_W){1'b0}}, minor_delta});
  assign err_sub    = err_sum - $signed({{(ERR_W-COORD_W){1'b0}}, major_delta});
  assign minor_move = err_sum > $signed(ERR_W'(0));

  always_comb begin
    pixel.px     = steep ? minor_pos : major_pos;
    pixel.py     = steep ? major_pos : minor_pos;
    pixel.colour = line_colour;
    pixel.last   = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (step_en) begin
      if (cmd == CMD_START) begin
        active <= 1'b1;
      end else if (active && last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && (cmd == CMD_START)) begin
      steep           <= setup.steep;
      major_pos       <= setup.major_pos;
      major_end       <= setup.major_end;
      minor_pos       <= setup.minor_pos;
      minor_step_down <= setup.minor_step_down;
      major_delta     <= setup.major_delta;
      minor_delta     <= setup.minor_delta;
      err_term        <= setup.err_init;
      line_colour     <= pen_colour;
    end else if (emit && !last) begin
      major_pos <= major_pos + COORD_W'(1);
      if (minor_move) begin
        minor_pos <= minor_step_down ? (minor_pos - COORD_W'(1)) : (minor_pos + COORD_W'(1));
        err_term  <= err_sub;
      end else begin
        err_term <= err_sum;
      end
    end
  end

endmodule

### tb/bresenham_line_raster_test.sv
module bresenham_line_raster_test;
  timeunit 1ns;
  timeprecision 1ps;

  import blr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    logic [COORD_W-1:0]  x;
    logic [ROW_W-1:0]    y;
    logic [ADDR_W-1:0]   addr;
    logic [COLOUR_W-1:0] colour;
    logic                last;
  } pixel_word_t;

  class pixel_scoreboard;
    logic [ADDR_W-1:0]   frame_base = '0;
    bit                  active;
    bit                  steep;
    bit                  step_down;
    int                  major_pos;
    int                  major_end;
    int                  minor_pos;
    int                  major_delta;
    int                  minor_delta;
    int                  err;
    logic [COLOUR_W-1:0] colour;
    pixel_word_t         due_pixels[$];
    int                  errors;

    function int span(int a, int b);
      return (a > b) ? a - b : b - a;
    endfunction

    // returns 1 for a transaction that the engine acts on
    function bit note_command(logic c, logic [COORD_W-1:0] sx, logic [ROW_W-1:0] sy,
                              logic [COORD_W-1:0] ex, logic [ROW_W-1:0] ey,
                              logic [COLOUR_W-1:0] col);
      int x0, y0, x1, y1, a0, b0, a1, b1, t;
      logic [ADDR_W-1:0] px, py;
      pixel_word_t w;
      if (c == CMD_START) begin
        x0 = (sx > SCREEN_WIDTH_DEF - 1) ? SCREEN_WIDTH_DEF - 1 : int'(sx);
        y0 = (sy > SCREEN_HEIGHT_DEF - 1) ? SCREEN_HEIGHT_DEF - 1 : int'(sy);
        x1 = (ex > SCREEN_WIDTH_DEF - 1) ? SCREEN_WIDTH_DEF - 1 : int'(ex);
        y1 = (ey > SCREEN_HEIGHT_DEF - 1) ? SCREEN_HEIGHT_DEF - 1 : int'(ey);
        steep = span(y1, y0) > span(x1, x0);
        if (steep) begin
          a0 = y0; b0 = x0; a1 = y1; b1 = x1;
        end else begin
          a0 = x0; b0 = y0; a1 = x1; b1 = y1;
        end
        if (a0 > a1) begin
          t = a0; a0 = a1; a1 = t;
          t = b0; b0 = b1; b1 = t;
        end
        major_pos = a0;
        major_end = a1;
        minor_pos = b0;
        major_delta = a1 - a0;
        minor_delta = span(b1, b0);
        step_down = !(b0 < b1);
        err = -(major_delta / 2);
        colour = col;
        active = 1'b1;
        return 1'b1;
      end
      if (!active)
        return 1'b0;
      px = steep ? minor_pos : major_pos;
      py = steep ? major_pos : minor_pos;
      w.x = px[COORD_W-1:0];
      w.y = py[ROW_W-1:0];
      w.addr = frame_base + (py << ROW_SHIFT) + (px << COL_SHIFT);
      w.colour = colour;
      w.last = (major_pos == major_end);
      due_pixels.push_back(w);
      if (w.last) begin
        active = 1'b0;
      end else begin
        err += minor_delta;
        if (err > 0) begin
          minor_pos = step_down ? (minor_pos - 1) & 'h1FF : (minor_pos + 1) & 'h1FF;
          err -= major_delta;
        end
        major_pos = (major_pos + 1) & 'h1FF;
      end
      return 1'b1;
    endfunction

    function void check_pixel(pixel_word_t got);
      pixel_word_t want;
      if (due_pixels.size() == 0) begin
        errors++;
        $error("unexpected pixel x %0d y %0d", got.x, got.y);
        return;
      end
      want = due_pixels.pop_front();
      if (got.x !== want.x) begin
        errors++;
        $error("pixel_x expected %0d got %0d", want.x, got.x);
      end
      if (got.y !== want.y) begin
        errors++;
        $error("pixel_y expected %0d got %0d", want.y, got.y);
      end
      if (got.addr !== want.addr) begin
        errors++;
        $error("pixel_addr expected %h got %h", want.addr, got.addr);
      end
      if (got.colour !== want.colour) begin
        errors++;
        $error("pixel_colour expected %h got %h", want.colour, got.colour);
      end
      if (got.last !== want.last) begin
        errors++;
        $error("last_pixel expected %0d got %0d", want.last, got.last);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [ADDR_W-1:0]   cfg_wdata = '0;
  logic                cmd_valid = 1'b0;
  logic                cmd_stall;
  logic                cmd = CMD_TICK;
  logic [COORD_W-1:0]  start_x = '0;
  logic [ROW_W-1:0]    start_y = '0;
  logic [COORD_W-1:0]  end_x = '0;
  logic [ROW_W-1:0]    end_y = '0;
  logic [COLOUR_W-1:0] pen_colour = '0;
  logic                pixel_valid;
  logic                pixel_stall = 1'b0;
  logic [COORD_W-1:0]  pixel_x;
  logic [ROW_W-1:0]    pixel_y;
  logic [ADDR_W-1:0]   pixel_addr;
  logic [COLOUR_W-1:0] pixel_colour;
  logic                last_pixel;

  pixel_scoreboard board;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int items_done = 0;
  int cycle_count = 0;

  bresenham_line_raster dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .start_x(start_x),
    .start_y(start_y),
    .end_x(end_x),
    .end_y(end_y),
    .pen_colour(pen_colour),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .pixel_addr(pixel_addr),
    .pixel_colour(pixel_colour),
    .last_pixel(last_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // pixel receiver: checks each pixel transaction, then picks next stall
  always @(posedge clk) begin
    pixel_word_t got;
    if (!rst && pixel_valid && !pixel_stall) begin
      got.x = pixel_x;
      got.y = pixel_y;
      got.addr = pixel_addr;
      got.colour = pixel_colour;
      got.last = last_pixel;
      board.check_pixel(got);
    end
    if (hold_left > 0) begin
      hold_left--;
      pixel_stall <= 1'b1;
    end else begin
      pixel_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task send_command(logic c, logic [COORD_W-1:0] sx, logic [ROW_W-1:0] sy,
                    logic [COORD_W-1:0] ex, logic [ROW_W-1:0] ey,
                    logic [COLOUR_W-1:0] col);
    while ($urandom_range(99) < gap_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    start_x <= sx;
    start_y <= sy;
    end_x <= ex;
    end_y <= ey;
    pen_colour <= col;
    do @(posedge clk); while (cmd_stall);
    if (board.note_command(c, sx, sy, ex, ey, col))
      items_done++;
  endtask

  task send_start(logic [COORD_W-1:0] sx, logic [ROW_W-1:0] sy,
                  logic [COORD_W-1:0] ex, logic [ROW_W-1:0] ey,
                  logic [COLOUR_W-1:0] col);
    send_command(CMD_START, sx, sy, ex, ey, col);
  endtask

  // payload of a tick is ignored, so it carries random bits
  task send_tick();
    send_command(CMD_TICK, COORD_W'($urandom), ROW_W'($urandom), COORD_W'($urandom),
                 ROW_W'($urandom), COLOUR_W'($urandom));
  endtask

  function int near_coord(int v, int limit);
    int n;
    n = v + int'($urandom_range(16)) - 8;
    if (n < 0)
      n = 0;
    if (n > limit - 1)
      n = limit - 1;
    return n;
  endfunction

  task send_random_line();
    int kind;
    logic [COORD_W-1:0] sx, ex;
    logic [ROW_W-1:0] sy, ey;
    kind = $urandom_range(99);
    if (kind < 4) begin
      sx = COORD_W'($urandom); sy = ROW_W'($urandom);
      ex = COORD_W'($urandom); ey = ROW_W'($urandom);
    end else if (kind < 7) begin
      sx = COORD_W'($urandom_range(SCREEN_WIDTH_DEF - 1));
      sy = ROW_W'($urandom_range(SCREEN_HEIGHT_DEF - 1));
      ex = COORD_W'($urandom_range(SCREEN_WIDTH_DEF - 1));
      ey = ROW_W'($urandom_range(SCREEN_HEIGHT_DEF - 1));
    end else begin
      sx = COORD_W'($urandom_range(SCREEN_WIDTH_DEF - 1));
      sy = ROW_W'($urandom_range(SCREEN_HEIGHT_DEF - 1));
      ex = COORD_W'(near_coord(sx, SCREEN_WIDTH_DEF));
      ey = ROW_W'(near_coord(sy, SCREEN_HEIGHT_DEF));
    end
    send_start(sx, sy, ex, ey, COLOUR_W'($urandom));
    // mostly walk the whole line, sometimes cut it short with the next start
    while (board.active) begin
      if ($urandom_range(99) < 2)
        break;
      send_tick();
    end
    if ($urandom_range(99) < 10)
      repeat ($urandom_range(1, 3)) send_tick();
  endtask

  task wait_for_idle();
    cmd_valid <= 1'b0;
    while (board.due_pixels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task load_frame_base(logic [ADDR_W-1:0] base);
    wait_for_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= base;
    @(posedge clk);
    board.frame_base = base;
    cfg_we <= 1'b0;
  endtask

  task run_phase(logic [ADDR_W-1:0] base, int gap, int stall, int hold, int target);
    int first;
    load_frame_base(base);
    gap_pct = gap;
    stall_pct = stall;
    hold_left = hold;
    first = items_done;
    while (items_done - first < target)
      send_random_line();
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // tick with no line, clamped corner line, single point, steep and
    // shallow lines stepping down, a start that replaces a line in progress
    send_tick();
    send_start(511, 255, 317, 238, 16'hFFFF);
    repeat (3) send_tick();
    send_start(0, 0, 0, 0, 16'h0000);
    repeat (2) send_tick();
    send_start(3, 6, 5, 2, COLOUR_W'($urandom));
    repeat (5) send_tick();
    send_start(0, 239, 3, 237, COLOUR_W'($urandom));
    repeat (4) send_tick();
    send_start(10, 10, 20, 12, COLOUR_W'($urandom));
    send_tick();
    send_start(319, 0, 319, 0, COLOUR_W'($urandom));
    send_tick();

    run_phase(32'hFFFF_FFFF, 0, 0, 0, 300);
    run_phase($urandom, 51, 0, 0, 300);
    run_phase($urandom, 0, 51, 0, 300);
    run_phase($urandom, 14, 14, 0, 300);
    run_phase(32'h0000_0000, 0, 0, 400, 300);

    wait_for_idle();
    if (board.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

### sim.f
rtl/blr_pkg.sv
rtl/blr_setup.sv
rtl/blr_walk.sv
rtl/bresenham_line_raster.sv
tb/bresenham_line_raster_test.sv
